// ----- rtl/lcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and codes of the longitudinal car plant: request kinds,
// register indexes, datapath operation codes and controller commands.
// ----------------------------------------------------------------------------
package lcp_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_FORCE   = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam logic [2:0] REG_TIME_STEP      = 3'd0;
   localparam logic [2:0] REG_LEAD_SPEED     = 3'd1;
   localparam logic [2:0] REG_INITIAL_SPEED  = 3'd2;
   localparam logic [2:0] REG_INITIAL_GAP    = 3'd3;
   localparam logic [2:0] REG_PULSE_DISTANCE = 3'd4;

   localparam logic [16:0] RESET_TIME_STEP      = 17'd655;
   localparam logic [31:0] RESET_LEAD_SPEED     = 32'd131072;
   localparam logic [31:0] RESET_INITIAL_SPEED  = 32'd6554;
   localparam logic [31:0] RESET_INITIAL_GAP    = 32'd655360;
   localparam logic [30:0] RESET_PULSE_DISTANCE = 31'd18324;

   // datapath operations of one Euler step, in issue order
   localparam logic [2:0] OP_SPEED_SQ = 3'd0;  // v*v
   localparam logic [2:0] OP_QUAD     = 3'd1;  // F2 * v^2, plus F0
   localparam logic [2:0] OP_LINEAR   = 3'd2;  // F1 * v, force minus resistance
   localparam logic [2:0] OP_ACCEL    = 3'd3;  // times 1/mass
   localparam logic [2:0] OP_SPEED    = 3'd4;  // v += dt*a
   localparam logic [2:0] OP_GAP      = 3'd5;  // gap += dt*(lead - v)
   localparam logic [2:0] OP_TRAVEL   = 3'd6;  // travelled += dt*v, hall pulse

   typedef struct packed {
      logic [30:0]        pulse_distance;
      logic signed [31:0] initial_gap;
      logic signed [31:0] initial_speed;
      logic signed [31:0] lead_speed;
      logic [16:0]        time_step;
   } lcp_cfg_type;

   typedef struct packed {
      logic       load_ops;   // latch multiplier operands for op
      logic [2:0] op;
      logic       mul_lo;     // low half partial product
      logic       mul_hi;     // high half partial product
      logic       mul_acc;    // sum the partial products
      logic       write_back; // commit result of op
      logic       set_force;
      logic       restart;
      logic       capture;    // load the response register
   } lcp_cmd_type;

   typedef struct packed {
      logic               hall_pulse;
      logic signed [31:0] lead_speed;
      logic signed [31:0] gap;
      logic signed [31:0] speed;
   } lcp_result_type;

endpackage

// ----- rtl/lcp_csr.sv -----
// ----------------------------------------------------------------------------
// lcp_csr
// APB-style register file: time step, lead speed, initial values, pulse
// distance.
// ----------------------------------------------------------------------------
module lcp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output lcp_pkg::lcp_cfg_type                cfg
);

   lcp_pkg::lcp_cfg_type cfg_ff;
   logic [2:0]           index;
   logic                 wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step      <= lcp_pkg::RESET_TIME_STEP;
         cfg_ff.lead_speed     <= lcp_pkg::RESET_LEAD_SPEED;
         cfg_ff.initial_speed  <= lcp_pkg::RESET_INITIAL_SPEED;
         cfg_ff.initial_gap    <= lcp_pkg::RESET_INITIAL_GAP;
         cfg_ff.pulse_distance <= lcp_pkg::RESET_PULSE_DISTANCE;
      end else if (wr_en) begin
         unique case (index)
            lcp_pkg::REG_TIME_STEP:      cfg_ff.time_step      <= csr_pwdata[16:0];
            lcp_pkg::REG_LEAD_SPEED:     cfg_ff.lead_speed     <= csr_pwdata;
            lcp_pkg::REG_INITIAL_SPEED:  cfg_ff.initial_speed  <= csr_pwdata;
            lcp_pkg::REG_INITIAL_GAP:    cfg_ff.initial_gap    <= csr_pwdata;
            lcp_pkg::REG_PULSE_DISTANCE: cfg_ff.pulse_distance <= csr_pwdata[30:0];
            default: ;  // unmapped, ignored
         endcase
      end
   end

   always_comb begin
      unique case (index)
         lcp_pkg::REG_TIME_STEP:      csr_prdata = {15'd0, cfg_ff.time_step};
         lcp_pkg::REG_LEAD_SPEED:     csr_prdata = cfg_ff.lead_speed;
         lcp_pkg::REG_INITIAL_SPEED:  csr_prdata = cfg_ff.initial_speed;
         lcp_pkg::REG_INITIAL_GAP:    csr_prdata = cfg_ff.initial_gap;
         lcp_pkg::REG_PULSE_DISTANCE: csr_prdata = {1'b0, cfg_ff.pulse_distance};
         default:                     csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- rtl/lcp_mul.sv -----
// ----------------------------------------------------------------------------
// lcp_mul
// Shared 64 x 33 signed multiplier, two passes through one 33 x 33 array.
// Product kept modulo 2^64.
// ----------------------------------------------------------------------------
module lcp_mul (
   input  logic                 clock,
   input  logic                 mul_lo,
   input  logic                 mul_hi,
   input  logic                 mul_acc,
   input  logic signed [63:0]   op_a,
   input  logic signed [32:0]   op_b,
   output logic signed [63:0]   product
);

   logic signed [32:0] half_a;
   logic signed [65:0] pp_in;
   logic signed [65:0] pp_ff;
   logic        [63:0] acc_ff;
   logic signed [63:0] prod_ff;

   // low half unsigned, high half carries the sign
   always_comb begin
      if (mul_hi) begin
         half_a = {op_a[63], op_a[63:32]};
      end else begin
         half_a = {1'b0, op_a[31:0]};
      end
      pp_in = half_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (mul_lo || mul_hi) begin
         pp_ff <= pp_in;
      end
      if (mul_hi) begin
         acc_ff <= pp_ff[63:0];
      end
      if (mul_acc) begin
         prod_ff <= acc_ff + {pp_ff[31:0], 32'd0};
      end
   end

   assign product = prod_ff;

endmodule

// ----- rtl/lcp_dpath.sv -----
// ----------------------------------------------------------------------------
// lcp_dpath
// Plant state, operand selection and write-back of the Euler step.
// ----------------------------------------------------------------------------
module lcp_dpath #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lcp_pkg::lcp_cmd_type    cmd,
   input  lcp_pkg::lcp_cfg_type    cfg,
   input  logic signed [31:0]      control_force,
   output lcp_pkg::lcp_result_type result
);

   localparam longint FX_ONE     = longint'(1) << FRACTION_BITS;
   localparam longint K_F0       = (907 * FX_ONE + 500) / 1000;
   localparam longint K_F1       = (5 * FX_ONE + 500) / 1000;
   localparam longint K_F2       = (25 * FX_ONE + 50000) / 100000;
   localparam longint K_INV_MASS = (100 * FX_ONE + 453) / 907;

   logic signed [31:0] ego_ff;
   logic signed [31:0] headway_ff;
   logic signed [31:0] drive_ff;
   logic signed [31:0] travel_ff;
   logic               pulse_ff;
   logic signed [63:0] tmp_ff;     // v^2, resistance, net force, accel in turn
   logic signed [63:0] op_a_ff;
   logic signed [32:0] op_b_ff;

   logic signed [63:0] op_a_in;
   logic signed [32:0] op_b_in;
   logic signed [63:0] product;
   logic signed [63:0] scaled;
   logic signed [63:0] ego_wide;
   logic signed [63:0] lead_wide;
   logic signed [32:0] step_b;
   logic signed [31:0] travel_sum;
   logic               pulse_hit;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   lcp_mul u_mul (
      .clock   (clock),
      .mul_lo  (cmd.mul_lo),
      .mul_hi  (cmd.mul_hi),
      .mul_acc (cmd.mul_acc),
      .op_a    (op_a_ff),
      .op_b    (op_b_ff),
      .product (product)
   );

   assign ego_wide  = {{32{ego_ff[31]}}, ego_ff};
   assign lead_wide = {{32{cfg.lead_speed[31]}}, cfg.lead_speed};
   assign step_b    = {16'd0, cfg.time_step};
   assign scaled    = product >>> FRACTION_BITS;   // floor

   always_comb begin
      unique case (cmd.op)
         lcp_pkg::OP_SPEED_SQ: begin
            op_a_in = ego_wide;
            op_b_in = {ego_ff[31], ego_ff};
         end
         lcp_pkg::OP_QUAD: begin
            op_a_in = tmp_ff;
            op_b_in = 33'(K_F2);
         end
         lcp_pkg::OP_LINEAR: begin
            op_a_in = ego_wide;
            op_b_in = 33'(K_F1);
         end
         lcp_pkg::OP_ACCEL: begin
            op_a_in = tmp_ff;
            op_b_in = 33'(K_INV_MASS);
         end
         lcp_pkg::OP_SPEED: begin
            op_a_in = tmp_ff;
            op_b_in = step_b;
         end
         lcp_pkg::OP_GAP: begin
            op_a_in = lead_wide - ego_wide;
            op_b_in = step_b;
         end
         lcp_pkg::OP_TRAVEL: begin
            op_a_in = ego_wide;
            op_b_in = step_b;
         end
         default: begin
            op_a_in = 64'sd0;
            op_b_in = 33'sd0;
         end
      endcase
   end

   assign travel_sum = sat32({{32{travel_ff[31]}}, travel_ff} + scaled);
   assign pulse_hit  = $signed({travel_sum[31], travel_sum})
                       >= $signed({2'b00, cfg.pulse_distance});

   always_ff @(posedge clock) begin
      if (cmd.load_ops) begin
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
      end
      if (cmd.write_back) begin
         unique case (cmd.op)
            lcp_pkg::OP_SPEED_SQ: tmp_ff <= scaled;
            lcp_pkg::OP_QUAD:     tmp_ff <= 64'(K_F0) + scaled;
            lcp_pkg::OP_LINEAR:
               tmp_ff <= {{32{drive_ff[31]}}, drive_ff} - (tmp_ff + scaled);
            lcp_pkg::OP_ACCEL:    tmp_ff <= scaled;
            default: ;
         endcase
      end
   end

   // plant state
   always_ff @(posedge clock) begin
      if (reset) begin
         ego_ff     <= lcp_pkg::RESET_INITIAL_SPEED;
         headway_ff <= lcp_pkg::RESET_INITIAL_GAP;
         drive_ff   <= 32'(K_F0);
         travel_ff  <= 32'sd0;
         pulse_ff   <= 1'b0;
      end else if (cmd.restart) begin
         ego_ff     <= cfg.initial_speed;
         headway_ff <= cfg.initial_gap;
         drive_ff   <= 32'(K_F0);
         travel_ff  <= 32'sd0;
      end else if (cmd.set_force) begin
         drive_ff <= control_force;
      end else if (cmd.write_back) begin
         unique case (cmd.op)
            lcp_pkg::OP_SPEED: ego_ff <= sat32(ego_wide + scaled);
            lcp_pkg::OP_GAP:
               headway_ff <= sat32({{32{headway_ff[31]}}, headway_ff} + scaled);
            lcp_pkg::OP_TRAVEL: begin
               pulse_ff  <= pulse_hit;
               travel_ff <= pulse_hit ? 32'sd0 : travel_sum;
            end
            default: ;
         endcase
      end
   end

   assign result.hall_pulse = pulse_ff;
   assign result.lead_speed = cfg.lead_speed;
   assign result.gap        = headway_ff;
   assign result.speed      = ego_ff;

endmodule

// ----- rtl/lcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcp_ctrl
// Sequencer: takes requests and steps the datapath through the seven
// multiply operations of a tick.
// ----------------------------------------------------------------------------
module lcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   input  logic                 out_free,
   output logic                 req_ready,
   output lcp_pkg::lcp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_LO   = 3'd2;
   localparam logic [2:0] S_HI   = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_WB   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == lcp_pkg::REQ_TICK) begin
               state_in = S_LOAD;
               op_in    = lcp_pkg::OP_SPEED_SQ;
            end
         end
         S_LOAD: state_in = S_LO;
         S_LO:   state_in = S_HI;
         S_HI:   state_in = S_ACC;
         S_ACC:  state_in = S_WB;
         S_WB: begin
            if (op_ff == lcp_pkg::OP_TRAVEL) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LOAD;
               op_in    = op_ff + 3'd1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= lcp_pkg::OP_SPEED_SQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.op         = op_ff;
      cmd.load_ops   = (state_ff == S_LOAD);
      cmd.mul_lo     = (state_ff == S_LO);
      cmd.mul_hi     = (state_ff == S_HI);
      cmd.mul_acc    = (state_ff == S_ACC);
      cmd.write_back = (state_ff == S_WB);
      cmd.set_force  = accept && (req_kind == lcp_pkg::REQ_FORCE);
      cmd.restart    = accept && (req_kind == lcp_pkg::REQ_RESTART);
      cmd.capture    = (state_ff == S_OUT) && out_free;
   end

endmodule

// ----- rtl/longitudinal_car_plant_step.sv -----
// ----------------------------------------------------------------------------
// longitudinal_car_plant_step
// Fixed-point forward Euler plant of a car following a lead car, for
// hardware-in-the-loop use. Ticks step the plant, force requests set the
// drive force, restart requests reload the initial values.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata / data                               | tuser
//  --------+-----+--------------------------------------------+----------
//  req_    | in  | [31:0] control_force                       | req_type
//  rsp_    | out | speed, gap, lead speed, hall pulse [96]    | -
//  csr_    | in  | APB, 5 registers at 4*i                    | -
//
//  A tick runs from acceptance to the response register as seven multiplies
//  on the one shared 64 x 33 multiplier, each through operand load, low pass,
//  high pass, sum and write-back, followed by the capture step; the next
//  request is taken in the cycle after capture.
//  Force, restart and unused-kind requests complete in their accept cycle and
//  give no response.
//  Reset (synchronous) restores the register defaults and the initial state.
//  A response waits in its register until taken; a new tick may run
//  meanwhile and only holds at its capture step.
//
module longitudinal_car_plant_step #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,

   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // [31:0] control_force
   input  logic [1:0]                         req_tuser,   // [1:0] req_type

   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [103:0]                       rsp_tdata,   // [31:0] speed_out,
                                                           // [63:32] gap_out,
                                                           // [95:64] lead_speed_out,
                                                           // [96] hall_pulse, rest 0

   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lcp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   lcp_pkg::lcp_cfg_type    cfg;
   lcp_pkg::lcp_cmd_type    cmd;
   lcp_pkg::lcp_result_type result;

   logic                    rsp_valid_ff;
   logic [103:0]            rsp_data_ff;
   logic                    out_free;

   // response register may be refilled when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   lcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .out_free  (out_free),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   lcp_dpath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .control_force (req_tdata),
      .result        (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_data_ff <= {7'd0, result};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- tb/longitudinal_car_plant_step_tb.sv -----
// ----------------------------------------------------------------------------
// longitudinal_car_plant_step_tb
// Self-checking bench for the Euler car plant. A directed table covers the
// field extremes, every request kind and the corner cases: zero time step,
// zero pulse distance, negative travel, saturation and the unused kind. It is
// followed by randomised phases, each with fresh register settings. Every
// response is checked field by field against a fixed-point bench model or a
// typed value, with random stalls on both streams and one long sink hold.
// ----------------------------------------------------------------------------
module longitudinal_car_plant_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRACTION_BITS = 16;

   // plant constants, rounded to the nearest fixed-point step
   localparam longint FX_ONE     = longint'(1) << FRACTION_BITS;
   localparam longint K_F0       = (907 * FX_ONE + 500) / 1000;
   localparam longint K_F1       = (5 * FX_ONE + 500) / 1000;
   localparam longint K_F2       = (25 * FX_ONE + 50000) / 100000;
   localparam longint K_INV_MASS = (100 * FX_ONE + 453) / 907;
   localparam longint S32_MAX    = 64'sd2147483647;
   localparam longint S32_MIN    = -64'sd2147483648;

   // request kind the plant ignores, and register slots past the last one
   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   localparam int RANDOM_ITEMS  = 1400;
   localparam int PHASES        = 8;
   localparam int HOLD_CYCLES   = 400;     // long sink hold-off
   localparam int SETTLE_CYCLES = 40;      // margin after the last owed response
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTED  = 10;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;     // [31:0] control_force
   logic [1:0]   req_tuser;     // [1:0] req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;     // [31:0] speed, [63:32] gap, [95:64] lead speed,
                                // [96] hall pulse, [103:97] zero
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [lcp_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   longitudinal_car_plant_step #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Plant model: shadow registers and state, stepped on every accepted request
   // --------------------------------------------------------------------------
   lcp_pkg::lcp_cfg_type plant_cfg;
   longint      sim_speed;
   longint      sim_gap;
   longint      sim_force;
   longint      sim_travel;

   // responses still owed by the block, oldest first
   lcp_pkg::lcp_result_type awaited_reports[$];

   int mismatch_count;
   int requests_sent;
   int ticks_sent;
   int reports_seen;
   int pulses_seen;
   int random_total;
   bit steady_stretch;   // no idling on either stream
   bit hold_done;

   function automatic longint floor_q(longint x);
      return x >>> FRACTION_BITS;   // arithmetic shift: rounds toward minus infinity
   endfunction

   function automatic longint clamp32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   function automatic void load_start_values();
      sim_speed  = longint'($signed(plant_cfg.initial_speed));
      sim_gap    = longint'($signed(plant_cfg.initial_gap));
      sim_force  = K_F0;
      sim_travel = 0;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
         lcp_pkg::REG_TIME_STEP:      plant_cfg.time_step      = value[16:0];
         lcp_pkg::REG_LEAD_SPEED:     plant_cfg.lead_speed     = value;
         lcp_pkg::REG_INITIAL_SPEED:  plant_cfg.initial_speed  = value;
         lcp_pkg::REG_INITIAL_GAP:    plant_cfg.initial_gap    = value;
         lcp_pkg::REG_PULSE_DISTANCE: plant_cfg.pulse_distance = value[30:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] register_view(logic [2:0] idx);
      case (idx)
         lcp_pkg::REG_TIME_STEP:     return {15'd0, plant_cfg.time_step};
         lcp_pkg::REG_LEAD_SPEED:    return plant_cfg.lead_speed;
         lcp_pkg::REG_INITIAL_SPEED: return plant_cfg.initial_speed;
         lcp_pkg::REG_INITIAL_GAP:   return plant_cfg.initial_gap;
         default:                    return {1'b0, plant_cfg.pulse_distance};
      endcase
   endfunction

   // One accepted request; returns 1 when it owes a response.
   function automatic bit advance_plant(logic [1:0] kind, logic [31:0] data,
                                        output lcp_pkg::lcp_result_type report);
      longint v;
      longint resist;
      longint accel;
      longint dt;
      longint lead;
      bit     pulse;
      report = '0;
      if (kind == lcp_pkg::REQ_FORCE) begin
         sim_force = longint'($signed(data));
         return 1'b0;
      end
      if (kind == lcp_pkg::REQ_RESTART) begin
         load_start_values();
         return 1'b0;
      end
      if (kind != lcp_pkg::REQ_TICK) return 1'b0;

      dt     = longint'(plant_cfg.time_step);
      lead   = longint'($signed(plant_cfg.lead_speed));
      v      = sim_speed;
      resist = K_F0 + floor_q(K_F1 * v) + floor_q(K_F2 * floor_q(v * v));
      accel  = floor_q((sim_force - resist) * K_INV_MASS);

      // speed first, then gap and travel use the new speed
      sim_speed  = clamp32(v + floor_q(dt * accel));
      sim_gap    = clamp32(sim_gap + floor_q(dt * (lead - sim_speed)));
      sim_travel = clamp32(sim_travel + floor_q(dt * sim_speed));

      pulse = (sim_travel >= longint'(plant_cfg.pulse_distance));
      if (pulse) sim_travel = 0;

      report.speed      = sim_speed[31:0];
      report.gap        = sim_gap[31:0];
      report.lead_speed = plant_cfg.lead_speed;
      report.hall_pulse = pulse;
      return 1'b1;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("mismatch on %s: expected %h, got %h at %0t ns",
                     what, want, got, $time);
      end
   endfunction

   // --------------------------------------------------------------------------
   // Response checker: each taken response against the oldest one owed
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      lcp_pkg::lcp_result_type got;
      lcp_pkg::lcp_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata[96:0];
         reports_seen++;
         if (got.hall_pulse) pulses_seen++;
         if (awaited_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("response with none owed: %h at %0t ns", rsp_tdata, $time);
         end else begin
            want = awaited_reports.pop_front();
            check_field("speed", want.speed, got.speed);
            check_field("gap", want.gap, got.gap);
            check_field("lead speed", want.lead_speed, got.lead_speed);
            check_field("hall pulse", 32'(want.hall_pulse), 32'(got.hall_pulse));
         end
         check_field("response padding", 32'd0, 32'(rsp_tdata[103:97]));
      end
   end

   // --------------------------------------------------------------------------
   // Sink: random stalls, a quiet stretch, and one long hold-off so that one
   // response sits in the output register, the next tick waits at capture and
   // the request stream backs up.
   // --------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && reports_seen >= 250) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= steady_stretch || ($urandom_range(99) >= 8);
      end
   end

   // --------------------------------------------------------------------------
   // Source side: request driver, register access, idle wait
   // --------------------------------------------------------------------------

   // Offers one request, holds it until taken, then steps the model. A typed
   // expectation, where given, replaces the model's for that tick.
   task automatic offer(logic [1:0] kind, logic [31:0] data, bit known,
                        lcp_pkg::lcp_result_type typed);
      lcp_pkg::lcp_result_type predicted;
      while (!steady_stretch && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      requests_sent++;
      if (advance_plant(kind, data, predicted)) begin
         awaited_reports.push_back(known ? typed : predicted);
         ticks_sent++;
      end
   endtask

   // Drops valid and waits until every owed response is in, plus a margin.
   task automatic wait_idle(int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the transfer completes at the edge that
   // sees pready. An idle cycle follows so psel drops between transfers.
   task automatic csr_transfer(bit is_write, logic [2:0] idx, logic [31:0] wdata,
                               output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_register(logic [2:0] idx, logic [31:0] value);
      logic [31:0] readback;
      csr_transfer(1'b1, idx, value, readback);
      apply_register(idx, value);
      if (idx <= lcp_pkg::REG_PULSE_DISTANCE) begin
         csr_transfer(1'b0, idx, 32'd0, readback);
         check_field($sformatf("register %0d readback", idx), register_view(idx), readback);
      end
   endtask

   // --------------------------------------------------------------------------
   // Directed table
   // --------------------------------------------------------------------------
   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [1:0]              req_type;
      logic [2:0]              reg_index;
      logic [31:0]             value;
      bit                      known;
      lcp_pkg::lcp_result_type report;
   } plan_row_type;

   plan_row_type directed_plan[$];

   function automatic void add_request(logic [1:0] kind, logic [31:0] value);
      plan_row_type row;
      row.kind      = ROW_REQUEST;
      row.req_type  = kind;
      row.reg_index = '0;
      row.value     = value;
      row.known     = 1'b0;
      row.report    = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void add_known_tick(logic [31:0] speed, logic [31:0] gap,
                                          logic [31:0] lead, bit pulse);
      plan_row_type row;
      row.kind              = ROW_REQUEST;
      row.req_type          = lcp_pkg::REQ_TICK;
      row.reg_index         = '0;
      row.value             = '0;
      row.known             = 1'b1;
      row.report.speed      = speed;
      row.report.gap        = gap;
      row.report.lead_speed = lead;
      row.report.hall_pulse = pulse;
      directed_plan.push_back(row);
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [31:0] value);
      plan_row_type row;
      row.kind      = ROW_REGISTER;
      row.req_type  = lcp_pkg::REQ_TICK;
      row.reg_index = idx;
      row.value     = value;
      row.known     = 1'b0;
      row.report    = '0;
      directed_plan.push_back(row);
   endfunction

   // --------------------------------------------------------------------------
   // Watchdog
   // --------------------------------------------------------------------------
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d responses still owed",
               cycles, awaited_reports.size());
      $display("longitudinal_car_plant_step_tb NOT OK");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin : stimulus
      lcp_pkg::lcp_result_type none;
      logic [31:0]    setting [5];
      logic [1:0]     kind;
      logic [31:0]    data;
      int             counted;
      int             roll;
      bit             lifelike;

      none           = '0;
      mismatch_count = 0;
      requests_sent  = 0;
      ticks_sent     = 0;
      reports_seen   = 0;
      pulses_seen    = 0;
      random_total   = 0;
      steady_stretch = 1'b0;
      hold_done      = 1'b0;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 32'd0;
      req_tuser   <= lcp_pkg::REQ_TICK;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      plant_cfg.time_step      = lcp_pkg::RESET_TIME_STEP;
      plant_cfg.lead_speed     = lcp_pkg::RESET_LEAD_SPEED;
      plant_cfg.initial_speed  = lcp_pkg::RESET_INITIAL_SPEED;
      plant_cfg.initial_gap    = lcp_pkg::RESET_INITIAL_GAP;
      plant_cfg.pulse_distance = lcp_pkg::RESET_PULSE_DISTANCE;
      load_start_values();

      // zero time step freezes the plant: the reset state reads straight back
      add_write(lcp_pkg::REG_TIME_STEP, 32'd0);
      add_known_tick(32'd6554, 32'd655360, 32'd131072, 1'b0);
      // zero pulse distance: a pulse on every tick with travel not negative
      add_write(lcp_pkg::REG_PULSE_DISTANCE, 32'd0);
      add_known_tick(32'd6554, 32'd655360, 32'd131072, 1'b1);
      add_request(lcp_pkg::REQ_FORCE, 32'h7FFF_FFFF);
      add_known_tick(32'd6554, 32'd655360, 32'd131072, 1'b1);
      // extremes loaded through restart, still frozen
      add_write(lcp_pkg::REG_LEAD_SPEED, 32'h8000_0000);
      add_write(lcp_pkg::REG_INITIAL_SPEED, 32'h7FFF_FFFF);
      add_write(lcp_pkg::REG_INITIAL_GAP, 32'h8000_0000);
      add_request(lcp_pkg::REQ_RESTART, 32'h0000_0000);
      add_known_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
      // one-second steps from full speed: saturation both ways
      add_write(lcp_pkg::REG_TIME_STEP, 32'd65536);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      add_request(lcp_pkg::REQ_FORCE, 32'h7FFF_FFFF);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      add_write(lcp_pkg::REG_TIME_STEP, 32'h0001_FFFF);
      add_request(lcp_pkg::REQ_TICK, 32'hFFFF_FFFF);
      add_request(lcp_pkg::REQ_FORCE, 32'h8000_0000);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      // reversing car: travel goes negative, so no pulse despite zero distance
      add_write(lcp_pkg::REG_LEAD_SPEED, 32'h7FFF_FFFF);
      add_write(lcp_pkg::REG_INITIAL_SPEED, 32'h8000_0000);
      add_write(lcp_pkg::REG_INITIAL_GAP, 32'h7FFF_FFFF);
      add_request(lcp_pkg::REQ_RESTART, 32'h0000_0000);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      // unused kind is dropped without a response
      add_request(REQ_UNUSED, 32'hFFFF_FFFF);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      // slots past the register file must change nothing
      add_write(lcp_pkg::REG_PULSE_DISTANCE, 32'h7FFF_FFFF);
      add_write(REG_SPARE_FIRST, 32'hFFFF_FFFF);
      add_write(REG_SPARE_LAST, 32'hFFFF_FFFF);
      add_write(lcp_pkg::REG_TIME_STEP, 32'd1);
      add_request(lcp_pkg::REQ_RESTART, 32'hFFFF_FFFF);
      add_request(lcp_pkg::REQ_FORCE, 32'd0);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);
      add_request(lcp_pkg::REQ_TICK, 32'h0000_0000);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_REGISTER) begin
            wait_idle(SETTLE_CYCLES);
            program_register(directed_plan[i].reg_index, directed_plan[i].value);
         end else begin
            offer(directed_plan[i].req_type, directed_plan[i].value,
                  directed_plan[i].known, directed_plan[i].report);
         end
      end

      // Random phases. Lifelike settings (road speeds, short pulse
      // distances) keep the pulse logic busy; the others sweep the whole range.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle(SETTLE_CYCLES);
         lifelike = 1'b0;
         case (phase)
            2, 5: begin
               setting[lcp_pkg::REG_TIME_STEP]      = $urandom_range(0, 131071);
               setting[lcp_pkg::REG_LEAD_SPEED]     = $urandom;
               setting[lcp_pkg::REG_INITIAL_SPEED]  = $urandom;
               setting[lcp_pkg::REG_INITIAL_GAP]    = $urandom;
               setting[lcp_pkg::REG_PULSE_DISTANCE] = $urandom;
            end
            3: begin
               setting[lcp_pkg::REG_TIME_STEP]      = 32'd65536;
               setting[lcp_pkg::REG_LEAD_SPEED]     = 32'h7FFF_FFFF;
               setting[lcp_pkg::REG_INITIAL_SPEED]  = 32'h8000_0000;
               setting[lcp_pkg::REG_INITIAL_GAP]    = 32'h7FFF_FFFF;
               setting[lcp_pkg::REG_PULSE_DISTANCE] = 32'd1;
            end
            6: begin
               setting[lcp_pkg::REG_TIME_STEP]      = 32'd1;
               setting[lcp_pkg::REG_LEAD_SPEED]     = 32'h8000_0000;
               setting[lcp_pkg::REG_INITIAL_SPEED]  = 32'h7FFF_FFFF;
               setting[lcp_pkg::REG_INITIAL_GAP]    = 32'h8000_0000;
               setting[lcp_pkg::REG_PULSE_DISTANCE] = 32'h7FFF_FFFF;
            end
            default: begin
               lifelike = 1'b1;
               setting[lcp_pkg::REG_TIME_STEP]      = $urandom_range(655, 6554);
               setting[lcp_pkg::REG_LEAD_SPEED]     = $urandom_range(0, 30 * 65536);
               setting[lcp_pkg::REG_INITIAL_SPEED]  = $urandom_range(0, 25 * 65536);
               setting[lcp_pkg::REG_INITIAL_GAP]    = $urandom_range(65536, 100 * 65536);
               setting[lcp_pkg::REG_PULSE_DISTANCE] = $urandom_range(3277, 131072);
            end
         endcase
         for (int r = 0; r < 5; r++) program_register(r[2:0], setting[r]);
         offer(lcp_pkg::REQ_RESTART, $urandom, 1'b0, none);

         counted = 0;
         while (counted < RANDOM_ITEMS / PHASES) begin
            steady_stretch = (random_total >= 500 && random_total < 800);
            // source pauses until the pipe has drained
            if (random_total == 1000) wait_idle(0);
            roll = $urandom_range(99);
            data = $urandom;
            if (roll < 70) begin
               kind = lcp_pkg::REQ_TICK;
            end else if (roll < 85) begin
               kind = lcp_pkg::REQ_FORCE;
               if (lifelike || $urandom_range(3) != 0)
                  data = $urandom_range(0, 40 * 65536) - 20 * 65536;
            end else if (roll < 92) begin
               kind = lcp_pkg::REQ_RESTART;
            end else begin
               kind = REQ_UNUSED;
            end
            offer(kind, data, 1'b0, none);
            if (kind != REQ_UNUSED) begin
               counted++;
               random_total++;
            end
         end
      end
      steady_stretch = 1'b0;

      wait_idle(DRAIN_CYCLES);

      $display("run covered %0d requests, %0d ticks and %0d hall pulses",
               requests_sent, ticks_sent, pulses_seen);
      $display("directed corners plus %0d random register settings, sink hold of %0d cycles",
               PHASES, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("longitudinal_car_plant_step_tb OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("longitudinal_car_plant_step_tb NOT OK");
      end
      $finish;
   end

endmodule
